// ===== src/pbhm_pkg.sv =====
package pbhm_pkg;

  localparam int BUS_WIDTH = 8;
  localparam int TICK_WIDTH = 16;
  localparam int IN_TDATA_WIDTH = 24;
  localparam int OUT_TDATA_WIDTH = 24;

  localparam logic [TICK_WIDTH-1:0] TIMEOUT_RESET = 16'd100;
  localparam logic [TICK_WIDTH-1:0] TICK_MAX = '1;

  // Handshake phase codes; the spare code behaves as idle
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_ASSERT = 2'd1;
  localparam logic [1:0] PH_CLEAR = 2'd2;

  // Bus operations
  localparam logic [1:0] OP_WR_ADDR = 2'd0;
  localparam logic [1:0] OP_RD_ADDR = 2'd1;
  localparam logic [1:0] OP_WR_DATA = 2'd2;
  localparam logic [1:0] OP_RD_DATA = 2'd3;

  // Status codes
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_ASSERT_TO = 2'd1;
  localparam logic [1:0] ST_CLEAR_TO = 2'd2;

  typedef struct packed {
    logic [BUS_WIDTH-1:0] bus_in;
    logic                 wait_level;
    logic [BUS_WIDTH-1:0] wr_byte;
    logic [1:0]           func;
    logic                 start_req;
  } in_item_t;

  typedef struct packed {
    logic [BUS_WIDTH-1:0] rd_byte;
    logic [1:0]           status;
    logic                 done_res;
    logic                 busy_res;
    logic [BUS_WIDTH-1:0] bus_out;
    logic                 drive_enable;
    logic                 data_strobe;
    logic                 addr_strobe;
    logic                 write_strobe;
  } out_item_t;

  typedef struct packed {
    logic valid;
    logic advance;
  } stage_ctl_t;

  function automatic logic op_is_read(input logic [1:0] op);
    return op[0];
  endfunction

  function automatic logic op_is_addr(input logic [1:0] op);
    return !op[1];
  endfunction

endpackage

// ===== src/pbhm_in_stage.sv =====
module pbhm_in_stage import pbhm_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [IN_TDATA_WIDTH-1:0] s_tdata,
  input  logic                      advance,
  output stage_ctl_t                ctl,
  output in_item_t                  item
);

  logic     valid;
  in_item_t item_reg;

  assign s_tready = !valid || advance;
  assign ctl.valid = valid;
  assign ctl.advance = advance;
  assign item = item_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (s_tready) begin
      valid <= s_tvalid;
    end
  end

  // Load the word on accept; hold otherwise
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item_reg <= in_item_t'(s_tdata[$bits(in_item_t)-1:0]);
    end
  end

endmodule

// ===== src/pbhm_core.sv =====
module pbhm_core import pbhm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [TICK_WIDTH-1:0] cfg_data,
  input  stage_ctl_t            ctl,
  input  in_item_t              item,
  output out_item_t             result
);

  logic [TICK_WIDTH-1:0] timeout_ticks;
  logic [1:0]            phase, phase_next;
  logic [1:0]            op_held, op_held_next;
  logic [BUS_WIDTH-1:0]  byte_held, byte_held_next;
  logic [TICK_WIDTH-1:0] tick_count, tick_count_next;
  logic                  port_is_input, port_is_input_next;
  logic [1:0]            error_held, error_held_next;
  logic [BUS_WIDTH-1:0]  read_value, read_value_next;

  logic [TICK_WIDTH-1:0] limit;
  logic [TICK_WIDTH-1:0] tick_inc;
  logic                  expired;
  logic                  done;
  logic                  in_assert;

  assign limit = (timeout_ticks == '0) ? TICK_WIDTH'(1) : timeout_ticks;
  assign tick_inc = (tick_count < TICK_MAX) ? tick_count + TICK_WIDTH'(1) : tick_count;
  assign expired = tick_inc >= limit;

  always_comb begin
    phase_next = phase;
    op_held_next = op_held;
    byte_held_next = byte_held;
    tick_count_next = tick_count;
    port_is_input_next = port_is_input;
    error_held_next = error_held;
    read_value_next = read_value;
    done = 1'b0;
    unique case (phase)
      PH_ASSERT: begin
        if (item.wait_level) begin
          if (op_is_read(op_held)) begin
            read_value_next = item.bus_in;
          end
          phase_next = PH_CLEAR;
          tick_count_next = '0;
        end else begin
          tick_count_next = tick_inc;
          if (expired) begin
            error_held_next = ST_ASSERT_TO;
            tick_count_next = '0;
            if (op_held == OP_RD_DATA) begin
              phase_next = PH_IDLE;
              done = 1'b1;
            end else begin
              if (op_held == OP_RD_ADDR) begin
                read_value_next = item.bus_in;
              end
              phase_next = PH_CLEAR;
            end
          end
        end
      end
      PH_CLEAR: begin
        if (!item.wait_level) begin
          phase_next = PH_IDLE;
          done = 1'b1;
        end else begin
          tick_count_next = tick_inc;
          if (expired) begin
            error_held_next = ST_CLEAR_TO;
            phase_next = PH_IDLE;
            done = 1'b1;
          end
        end
      end
      default: begin
        phase_next = PH_IDLE;
        if (item.start_req) begin
          op_held_next = item.func;
          byte_held_next = op_is_read(item.func) ? '0 : item.wr_byte;
          port_is_input_next = op_is_read(item.func);
          error_held_next = ST_OK;
          tick_count_next = '0;
          phase_next = PH_ASSERT;
        end
      end
    endcase
  end

  assign in_assert = (phase_next == PH_ASSERT);

  always_comb begin
    result.write_strobe = in_assert && !op_is_read(op_held_next);
    result.addr_strobe = in_assert && op_is_addr(op_held_next);
    result.data_strobe = in_assert && !op_is_addr(op_held_next);
    result.drive_enable = !port_is_input_next;
    result.bus_out = result.write_strobe ? byte_held_next : '0;
    result.busy_res = (phase_next != PH_IDLE);
    result.done_res = done;
    result.status = error_held_next;
    result.rd_byte = read_value_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      timeout_ticks <= cfg_data;
    end
  end

  // Advance the handshake by one tick per consumed word
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      op_held <= OP_WR_ADDR;
      byte_held <= '0;
      tick_count <= '0;
      port_is_input <= 1'b0;
      error_held <= ST_OK;
      read_value <= '0;
    end else if (ctl.valid && ctl.advance) begin
      phase <= phase_next;
      op_held <= op_held_next;
      byte_held <= byte_held_next;
      tick_count <= tick_count_next;
      port_is_input <= port_is_input_next;
      error_held <= error_held_next;
      read_value <= read_value_next;
    end
  end

endmodule

// ===== src/pbhm_out_stage.sv =====
module pbhm_out_stage import pbhm_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  stage_ctl_t                 ctl,
  input  out_item_t                  result,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [OUT_TDATA_WIDTH-1:0] m_tdata,
  output logic                       advance
);

  out_item_t result_reg;

  // Take a new result whenever the register is empty or being drained
  assign advance = !m_tvalid || m_tready;
  assign m_tdata = OUT_TDATA_WIDTH'(result_reg);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.valid && advance) begin
      result_reg <= result;
    end
  end

endmodule

// ===== src/parallel_bus_handshake_master.sv =====
// Channel   Direction  Payload (tdata, lowest bit first)
// s_*       in         start_req, func[2], wr_byte[8], wait_level, bus_in[8]  (24 bits)
// m_*       out        write_strobe, addr_strobe, data_strobe, drive_enable,
//                      bus_out[8], busy_res, done_res, status[2], rd_byte[8]  (24 bits)
// cfg_*     in         timeout_ticks[16], always ready
//
// One input word is one bus tick; a word can be accepted every cycle while
// the m_* side is not stalled. Each word passes the input register, then the
// handshake step into the result register, to give its matching m_* word.
// Reset (rst, synchronous) empties both registers, idles the handshake and
// sets timeout_ticks to 100. A stalled m_tready holds the result register,
// which in turn holds the input register and drops s_tready once it is full.
module parallel_bus_handshake_master import pbhm_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  // start_req[0], func[2:1], wr_byte[10:3], wait_level[11], bus_in[19:12], zero pad
  input  logic [IN_TDATA_WIDTH-1:0]  s_tdata,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  // write_strobe[0], addr_strobe[1], data_strobe[2], drive_enable[3],
  // bus_out[11:4], busy_res[12], done_res[13], status[15:14], rd_byte[23:16]
  output logic [OUT_TDATA_WIDTH-1:0] m_tdata,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [TICK_WIDTH-1:0]      cfg_data
);

  stage_ctl_t ctl;
  in_item_t   item;
  out_item_t  result;
  logic       advance;

  // Register writes are taken at any time
  assign cfg_ready = 1'b1;

  pbhm_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .advance  (advance),
    .ctl      (ctl),
    .item     (item)
  );

  // Step the strobe/wait handshake once per word
  pbhm_core u_core (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .ctl      (ctl),
    .item     (item),
    .result   (result)
  );

  pbhm_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .result   (result),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .advance  (advance)
  );

endmodule
